// ===== sv/rhc_pkg.sv =====
// Package for the RGB to HSV converter: field widths and the record that
// moves from one divider cell to the next. No dependencies.
package rhc_pkg;

  localparam int unsigned CHAN_W = 8;   // one color channel
  localparam int unsigned QUOT_W = 16;  // hue and saturation fraction width
  localparam int unsigned HDIV_W = 11;  // 6 * (max - min) fits in 11 bits
  localparam int unsigned SDIV_W = CHAN_W;

  // Partial state of both long divisions, plus the value channel riding along
  typedef struct packed {
    logic [HDIV_W-1:0] hue_rem;
    logic [HDIV_W-1:0] hue_div;
    logic [QUOT_W-1:0] hue_quot;
    logic [SDIV_W-1:0] sat_rem;
    logic [SDIV_W-1:0] sat_div;
    logic [QUOT_W-1:0] sat_low;   // numerator bits not yet shifted in
    logic [QUOT_W-1:0] sat_quot;
    logic [CHAN_W-1:0] brightness;
  } div_stage_t;

endpackage

// ===== sv/rhc_if.sv =====
// Valid/ready channel interfaces of the RGB to HSV converter: pixel in,
// HSV result out. No dependencies.
interface rhc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface rhc_hsv_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue;
  logic [15:0] saturation;
  logic [7:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// ===== sv/rhc_front.sv =====
// Front stage: max/min, hue sector offset and the division operands.
// Depends on rhc_pkg.
module rhc_front
  import rhc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  output logic              out_valid,
  input  logic              out_ready,
  output div_stage_t        out_data
);

  logic [CHAN_W-1:0] hi;
  logic [CHAN_W-1:0] lo;
  logic [CHAN_W-1:0] diff;
  logic [HDIV_W-1:0] diff_w;
  logic [HDIV_W-1:0] six_d;
  logic [HDIV_W-1:0] t_num;
  logic [23:0]       sat_num;
  div_stage_t        data_next;

  always_comb begin
    hi     = (red > green) ? red : green;
    hi     = (hi > blue) ? hi : blue;
    lo     = (red < green) ? red : green;
    lo     = (lo < blue) ? lo : blue;
    diff   = hi - lo;
    diff_w = HDIV_W'(diff);
    six_d  = (diff_w << 2) + (diff_w << 1);
    // Sector offset; intermediate wrap is harmless since the sum is in [0, 6d)
    if (hi == red) begin
      if (green >= blue) t_num = HDIV_W'(green) - HDIV_W'(blue);
      else               t_num = six_d - (HDIV_W'(blue) - HDIV_W'(green));
    end else if (hi == green) begin
      t_num = (diff_w << 1) + HDIV_W'(blue) - HDIV_W'(red);
    end else begin
      t_num = (diff_w << 2) + HDIV_W'(red) - HDIV_W'(green);
    end
    sat_num = {diff, 16'h0000} - 24'(diff);  // d * 65535

    data_next.hue_rem    = (diff == '0) ? '0 : t_num;
    data_next.hue_div    = (diff == '0) ? '1 : six_d;  // grey: quotient stays 0
    data_next.hue_quot   = '0;
    data_next.sat_rem    = sat_num[23:16];
    data_next.sat_div    = (hi == '0) ? '1 : hi;       // black: quotient stays 0
    data_next.sat_low    = sat_num[15:0];
    data_next.sat_quot   = '0;
    data_next.brightness = hi;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== sv/rhc_div_cell.sv =====
// One restoring-division cell: retires one quotient bit of hue and of
// saturation and hands the partial result to the next cell. Depends on rhc_pkg.
module rhc_div_cell
  import rhc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  div_stage_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output div_stage_t out_data
);

  logic [HDIV_W:0]   hue_trial;
  logic              hue_bit;
  logic [SDIV_W:0]   sat_trial;
  logic              sat_bit;
  div_stage_t        data_next;

  always_comb begin
    data_next = in_data;
    // Hue numerator is t shifted left, so only zeros come in from below
    hue_trial = {in_data.hue_rem, 1'b0};
    hue_bit   = (hue_trial >= {1'b0, in_data.hue_div});
    data_next.hue_rem  = hue_bit ? HDIV_W'(hue_trial - {1'b0, in_data.hue_div})
                                 : HDIV_W'(hue_trial);
    data_next.hue_quot = {in_data.hue_quot[QUOT_W-2:0], hue_bit};

    sat_trial = {in_data.sat_rem, in_data.sat_low[QUOT_W-1]};
    sat_bit   = (sat_trial >= {1'b0, in_data.sat_div});
    data_next.sat_rem  = sat_bit ? SDIV_W'(sat_trial - {1'b0, in_data.sat_div})
                                 : SDIV_W'(sat_trial);
    data_next.sat_low  = {in_data.sat_low[QUOT_W-2:0], 1'b0};
    data_next.sat_quot = {in_data.sat_quot[QUOT_W-2:0], sat_bit};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== sv/rgb_to_hsv_convert_core.sv =====
// Top level of the RGB to HSV converter: front stage and a row of divider
// cells. Depends on rhc_pkg, rhc_if, rhc_front and rhc_div_cell.
//
// Usage:
//   pixel : sink channel, one 8-bit RGB pixel per transaction.
//   hsv   : source channel, one result per transaction: hue as a 16-bit
//           fraction of a turn, saturation with 65535 as 1.0, brightness as
//           the largest channel. Grey pixels give hue 0, black pixels give
//           saturation 0 as well.
//   Pipeline: a pixel passes through one registered front stage (max, min,
//   sector offset) and then sixteen registered divider cells, each retiring
//   one quotient bit of both divisions.
//   Throughput: one pixel per cycle while hsv is not stalled; each cell
//   holds one pixel, so up to 17 pixels are in flight.
//   Stall: when hsv.ready is low, the result holds in the last cell and
//   empty cells upstream keep filling; pixel.ready drops only once every
//   cell is occupied. Ready propagates combinationally up the chain.
//   Reset (rst, synchronous): clears all valid flags, the chain is empty.
module rgb_to_hsv_convert_core
  import rhc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  rhc_pixel_if.sink    pixel,
  rhc_hsv_if.source    hsv
);

  div_stage_t stage       [QUOT_W+1];
  logic       stage_valid [QUOT_W+1];
  logic       stage_ready [QUOT_W+1];

  // Operand preparation
  rhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .red       (pixel.red_in),
    .green     (pixel.green_in),
    .blue      (pixel.blue_in),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_data  (stage[0])
  );

  // One quotient bit per cell, most significant first
  for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_data   (stage[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_data  (stage[i+1])
    );
  end

  // Last cell is the output register
  assign stage_ready[QUOT_W] = hsv.ready;
  assign hsv.valid      = stage_valid[QUOT_W];
  assign hsv.hue        = stage[QUOT_W].hue_quot;
  assign hsv.saturation = stage[QUOT_W].sat_quot;
  assign hsv.brightness = stage[QUOT_W].brightness;

`ifndef NO_ASSERTIONS
  // A black pixel yields zero saturation and zero hue
  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    (hsv.valid && hsv.brightness == '0) |-> (hsv.saturation == '0 && hsv.hue == '0))
    else $error("black pixel gave nonzero hue or saturation");

  // Zero saturation only for grey pixels, which have hue 0
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    (hsv.valid && hsv.saturation == '0) |-> (hsv.hue == '0))
    else $error("grey pixel gave nonzero hue");

  // An empty output register means the whole chain can take a pixel
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !hsv.valid |-> pixel.ready)
    else $error("input stalled while output register is empty");

  // A nonzero saturation comes from a nonzero maximum
  a_sat_needs_value: assert property (@(posedge clk) disable iff (rst)
    (hsv.valid && hsv.saturation != '0) |-> (hsv.brightness != '0))
    else $error("saturation set for a black pixel");
`endif

endmodule
